// ===== hdl/etok_pkg.sv =====
// ----------------------------------------------------------------------------
// etok_pkg - shared types and constants of the expression tokeniser
// Token kinds, scan modes, character codes and the records passed between
// the scanner, the queue and the output sequencer.
// ----------------------------------------------------------------------------
package etok_pkg;

	// Width of a token length (holds 0 up to the largest buffer, 32 bytes).
	localparam int LEN_W  = 6;
	// Width of the token text on the result side: 32 bytes.
	localparam int TEXT_W = 256;
	// Number of requests the queue between scanner and output can hold.
	localparam int QUEUE_DEPTH = 2;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_LC_A  = 8'h61;
	localparam logic [7:0] CH_LC_Z  = 8'h7A;
	localparam logic [7:0] CH_UC_A  = 8'h41;
	localparam logic [7:0] CH_UC_Z  = 8'h5A;
	localparam logic [7:0] CH_P     = 8'h70;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_I     = 8'h69;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_T     = 8'h74;

	typedef enum logic [3:0] {
		KIND_END   = 4'd0,
		KIND_NUM   = 4'd1,
		KIND_ID    = 4'd2,
		KIND_PRINT = 4'd3,
		KIND_PLUS  = 4'd4,
		KIND_MINUS = 4'd5,
		KIND_MUL   = 4'd6,
		KIND_DIV   = 4'd7,
		KIND_EQ    = 4'd8,
		KIND_SEMI  = 4'd9
	} etok_kind_t;

	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_IDENT   = 3'd1,
		MODE_NUMBER  = 3'd2,
		MODE_SLASH   = 3'd3,
		MODE_COMMENT = 3'd4
	} etok_mode_t;

	// One queue entry: everything a single source byte gives. The first
	// result is a buffered token or a held slash, the second at most one byte.
	typedef struct packed {
		logic              has_a;
		etok_kind_t        a_kind;
		logic [LEN_W-1:0]  a_len;
		logic [TEXT_W-1:0] a_text;
		logic              a_ovf;
		logic              has_b;
		etok_kind_t        b_kind;
		logic              b_one;
		logic [7:0]        b_byte;
	} etok_entry_t;

	// One result item as shown on the output.
	typedef struct packed {
		etok_kind_t        kind;
		logic [LEN_W-1:0]  length;
		logic [TEXT_W-1:0] text;
		logic              overflow;
		logic              last;
	} etok_result_t;

endpackage

// ===== hdl/etok_front.sv =====
// ----------------------------------------------------------------------------
// etok_front - byte scanner
// Classifies each source byte, tracks the scan mode, collects token bytes and
// pushes one queue entry for every byte that completes one or two tokens.
// ----------------------------------------------------------------------------
module etok_front #(
	parameter int MAX_TOKEN_LEN = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [7:0]           char_in,
	output logic                 in_ready,
	input  logic                 q_full,
	output logic                 push,
	output etok_pkg::etok_entry_t push_entry
);
	import etok_pkg::*;

	localparam int IDX_W = (MAX_TOKEN_LEN > 1) ? $clog2(MAX_TOKEN_LEN) : 1;

	typedef struct packed {
		etok_mode_t new_mode;
		logic       start;
		logic       emit;
		etok_kind_t kind;
		logic       one;
	} idle_act_t;

	etok_mode_t       mode_q, mode_d;
	logic [LEN_W-1:0] token_len_q;
	logic             len_ovf_q;
	logic [7:0]       buf_q [MAX_TOKEN_LEN];

	logic              acc;
	logic              is_alpha, is_digit, is_lf, is_nul, is_slash;
	logic              is_print;
	logic              append, start, take_idle, from_buf;
	logic              has_a;
	etok_kind_t        a_kind;
	logic [TEXT_W-1:0] buf_text;
	idle_act_t         act;

	// Action of a byte met with no token pending.
	function automatic idle_act_t idle_action(input logic [7:0] c);
		idle_act_t r;
		r.new_mode = MODE_IDLE;
		r.start    = 1'b0;
		r.emit     = 1'b1;
		r.kind     = KIND_END;
		r.one      = 1'b1;
		if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
			r.emit = 1'b0;
		end else if ((c >= CH_LC_A && c <= CH_LC_Z) || (c >= CH_UC_A && c <= CH_UC_Z)) begin
			r.new_mode = MODE_IDENT;
			r.start    = 1'b1;
			r.emit     = 1'b0;
		end else if (c >= CH_0 && c <= CH_9) begin
			r.new_mode = MODE_NUMBER;
			r.start    = 1'b1;
			r.emit     = 1'b0;
		end else if (c == CH_SLASH) begin
			r.new_mode = MODE_SLASH;
			r.emit     = 1'b0;
		end else if (c == CH_NUL) begin
			r.one = 1'b0;
		end else begin
			unique case (c)
				CH_PLUS:  r.kind = KIND_PLUS;
				CH_MINUS: r.kind = KIND_MINUS;
				CH_STAR:  r.kind = KIND_MUL;
				CH_EQ:    r.kind = KIND_EQ;
				CH_SEMI:  r.kind = KIND_SEMI;
				default:  r.kind = KIND_END;
			endcase
		end
		return r;
	endfunction

	assign in_ready = !q_full;
	assign acc      = in_valid && in_ready;

	assign is_alpha = (char_in >= CH_LC_A && char_in <= CH_LC_Z) ||
	                  (char_in >= CH_UC_A && char_in <= CH_UC_Z);
	assign is_digit = (char_in >= CH_0 && char_in <= CH_9);
	assign is_lf    = (char_in == CH_LF);
	assign is_nul   = (char_in == CH_NUL);
	assign is_slash = (char_in == CH_SLASH);
	assign act      = idle_action(char_in);

	assign is_print = !len_ovf_q && token_len_q == LEN_W'(5) &&
	                  buf_q[0] == CH_P && buf_q[1] == CH_R && buf_q[2] == CH_I &&
	                  buf_q[3] == CH_N && buf_q[4] == CH_T;

	// Buffered text, zero from the token length upwards.
	always_comb begin
		buf_text = '0;
		for (int i = 0; i < MAX_TOKEN_LEN; i++) begin
			if (LEN_W'(i) < token_len_q) begin
				buf_text[8*i +: 8] = buf_q[i];
			end
		end
	end

	// Next scan mode.
	always_comb begin
		unique case (mode_q)
			MODE_IDENT:   mode_d = (is_alpha || is_digit) ? MODE_IDENT : act.new_mode;
			MODE_NUMBER:  mode_d = is_digit ? MODE_NUMBER : act.new_mode;
			MODE_SLASH:   mode_d = is_slash ? MODE_COMMENT : act.new_mode;
			MODE_COMMENT: mode_d = (is_lf || is_nul) ? MODE_IDLE : MODE_COMMENT;
			default:      mode_d = act.new_mode;
		endcase
	end

	// Scanner actions for the current byte.
	always_comb begin
		append    = 1'b0;
		take_idle = 1'b0;
		has_a     = 1'b0;
		from_buf  = 1'b0;
		a_kind    = KIND_END;
		unique case (mode_q)
			MODE_IDENT: begin
				if (is_alpha || is_digit) begin
					append = 1'b1;
				end else begin
					has_a     = 1'b1;
					from_buf  = 1'b1;
					a_kind    = is_print ? KIND_PRINT : KIND_ID;
					take_idle = 1'b1;
				end
			end
			MODE_NUMBER: begin
				if (is_digit) begin
					append = 1'b1;
				end else begin
					has_a     = 1'b1;
					from_buf  = 1'b1;
					a_kind    = KIND_NUM;
					take_idle = 1'b1;
				end
			end
			MODE_SLASH: begin
				if (!is_slash) begin
					has_a     = 1'b1;
					a_kind    = KIND_DIV;
					take_idle = 1'b1;
				end
			end
			MODE_COMMENT: begin
				// A NUL ends the comment and still reports end of input.
				take_idle = is_nul;
			end
			default: begin
				take_idle = 1'b1;
			end
		endcase
		start = take_idle && act.start;

		push_entry.has_a  = has_a;
		push_entry.a_kind = a_kind;
		push_entry.a_len  = from_buf ? token_len_q : LEN_W'(1);
		push_entry.a_text = from_buf ? buf_text : {{(TEXT_W-8){1'b0}}, CH_SLASH};
		push_entry.a_ovf  = from_buf && len_ovf_q;
		push_entry.has_b  = take_idle && act.emit;
		push_entry.b_kind = act.kind;
		push_entry.b_one  = act.one;
		push_entry.b_byte = char_in;
		push = acc && (has_a || (take_idle && act.emit));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_IDLE;
			token_len_q <= '0;
			len_ovf_q   <= 1'b0;
		end else if (acc) begin
			mode_q <= mode_d;
			if (start) begin
				token_len_q <= LEN_W'(1);
				len_ovf_q   <= 1'b0;
			end else if (append) begin
				if (token_len_q < LEN_W'(MAX_TOKEN_LEN)) begin
					token_len_q <= token_len_q + LEN_W'(1);
				end else begin
					len_ovf_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && start) begin
			buf_q[0] <= char_in;
		end else if (acc && append && token_len_q < LEN_W'(MAX_TOKEN_LEN)) begin
			buf_q[token_len_q[IDX_W-1:0]] <= char_in;
		end
	end

`ifndef ASSERT_OFF
	a_len_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		token_len_q <= LEN_W'(MAX_TOKEN_LEN))
		else $error("token length beyond buffer");

	a_ovf_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		len_ovf_q |-> token_len_q == LEN_W'(MAX_TOKEN_LEN))
		else $error("overflow flagged with buffer not full");
`endif

endmodule

// ===== hdl/etok_queue.sv =====
// ----------------------------------------------------------------------------
// etok_queue - short queue between scanner and output sequencer
// Holds completed-byte entries so that either side may stall on its own.
// ----------------------------------------------------------------------------
module etok_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  etok_pkg::etok_entry_t push_entry,
	output logic                  full,
	input  logic                  pop,
	output etok_pkg::etok_entry_t pop_entry,
	output logic                  empty
);
	import etok_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	etok_entry_t      mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty     = (count_q == '0);
	assign pop_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

`ifndef ASSERT_OFF
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue read while empty");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue written while full");
`endif

endmodule

// ===== hdl/etok_back.sv =====
// ----------------------------------------------------------------------------
// etok_back - output sequencer
// Takes queue entries and presents their one or two results, one per cycle,
// from an output register that holds while the receiver stalls.
// ----------------------------------------------------------------------------
module etok_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  etok_pkg::etok_entry_t  q_entry,
	input  logic                   q_empty,
	output logic                   q_pop,
	output logic                   out_valid,
	input  logic                   out_ready,
	output etok_pkg::etok_result_t out_result
);
	import etok_pkg::*;

	logic         out_valid_q;
	etok_result_t out_q;
	logic         pend_b_q;
	etok_kind_t   pend_kind_q;
	logic         pend_one_q;
	logic [7:0]   pend_byte_q;
	logic         slot_free, load_b;

	// A one-byte (or empty, for end of input) result, always the last.
	function automatic etok_result_t single_result(input etok_kind_t k, input logic one,
	                                               input logic [7:0] b);
		etok_result_t r;
		r.kind     = k;
		r.length   = one ? LEN_W'(1) : '0;
		r.text     = {{(TEXT_W-8){1'b0}}, (one ? b : 8'h00)};
		r.overflow = 1'b0;
		r.last     = 1'b1;
		return r;
	endfunction

	assign slot_free  = !out_valid_q || out_ready;
	assign load_b     = slot_free && pend_b_q;
	assign q_pop      = slot_free && !pend_b_q && !q_empty;
	assign out_valid  = out_valid_q;
	assign out_result = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_b_q    <= 1'b0;
		end else begin
			if (slot_free) begin
				out_valid_q <= pend_b_q || !q_empty;
			end
			if (load_b) begin
				pend_b_q <= 1'b0;
			end else if (q_pop) begin
				pend_b_q <= q_entry.has_a && q_entry.has_b;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_b) begin
			out_q <= single_result(pend_kind_q, pend_one_q, pend_byte_q);
		end else if (q_pop) begin
			pend_kind_q <= q_entry.b_kind;
			pend_one_q  <= q_entry.b_one;
			pend_byte_q <= q_entry.b_byte;
			if (q_entry.has_a) begin
				out_q.kind     <= q_entry.a_kind;
				out_q.length   <= q_entry.a_len;
				out_q.text     <= q_entry.a_text;
				out_q.overflow <= q_entry.a_ovf;
				out_q.last     <= !q_entry.has_b;
			end else begin
				out_q <= single_result(q_entry.b_kind, q_entry.b_one, q_entry.b_byte);
			end
		end
	end

`ifndef ASSERT_OFF
	a_pend_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		pend_b_q |-> (out_valid_q && !out_q.last))
		else $error("second result pending behind a last or empty output");
`endif

endmodule

// ===== hdl/expression_tokenizer.sv =====
// ----------------------------------------------------------------------------
// expression_tokenizer - streaming lexical tokeniser for a small expression
// language
// Turns a stream of ASCII source bytes into tokens: numbers, identifiers,
// the print keyword, the six one-byte symbols and end markers.
// ----------------------------------------------------------------------------
// Usage:
// The slave side takes one source byte per request in s_tdata. The master
// side gives one token per request: its kind in m_tuser, its length, text and
// overflow flag in m_tdata, and m_tlast on the final token caused by a byte.
// A byte may cause no token (whitespace, comment text, a letter or digit that
// extends a token), one token, or two (a pending token ended by a symbol).
// Throughput is one source byte per cycle while each byte gives at most one
// token and the receiver does not stall; a byte giving two tokens occupies
// the output with its two results in turn, and that single output register
// sets the rate. The scanner pushes an entry into a two-entry queue at the
// edge that takes the byte, and the output sequencer then loads it into the
// output register. If the receiver stalls, the output holds, the queue fills
// and s_tready falls; the scanner waits without losing its state.
// After reset the scanner is idle with no pending token, the queue and the
// output are empty; the token buffer is not cleared, as only bytes below
// the current token length are ever read.
// ----------------------------------------------------------------------------
module expression_tokenizer #(
	parameter int MAX_TOKEN_LEN = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] char_in
	output logic         m_tvalid,
	input  logic         m_tready,
	// [5:0] length, [69:6] text_0, [133:70] text_1, [197:134] text_2,
	// [261:198] text_3, [262] overflow, [263] zero
	output logic [263:0] m_tdata,
	output logic [3:0]   m_tuser,   // [3:0] kind
	output logic         m_tlast    // last
);
	import etok_pkg::*;

	// Queue traffic between the scanner and the output sequencer.
	logic         push, q_full, q_pop, q_empty;
	etok_entry_t  push_entry, pop_entry;
	etok_result_t result;

	// Scanner: classifies every byte and keeps the token being collected.
	etok_front #(
		.MAX_TOKEN_LEN(MAX_TOKEN_LEN)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.char_in   (s_tdata),
		.in_ready  (s_tready),
		.q_full    (q_full),
		.push      (push),
		.push_entry(push_entry)
	);

	// The queue decouples the scanner from a stalled receiver.
	etok_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.full      (q_full),
		.pop       (q_pop),
		.pop_entry (pop_entry),
		.empty     (q_empty)
	);

	// Output sequencer: splits an entry into its results, one per cycle while the receiver takes them.
	etok_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_entry   (pop_entry),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_result(result)
	);

	// Pack the result fields, lowest field in the lowest bits.
	assign m_tdata = {1'b0, result.overflow, result.text, result.length};
	assign m_tuser = result.kind;
	assign m_tlast = result.last;

endmodule
